/* design/tdfsm_pkg.sv */
`default_nettype none

package tdfsm_pkg;

    localparam int CODE_W = 8;
    localparam int CNT_W  = 4;
    localparam int EV_W   = 2;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam int SIU_W  = 5;

    localparam logic REG_STATES_IN_USE = 1'b0;

    typedef enum logic [1:0] {
        OP_LOAD_STATE = 2'd0,
        OP_LOAD_TRANS = 2'd1,
        OP_STEP       = 2'd2,
        OP_SET_STATE  = 2'd3
    } t_op;

    localparam logic [EV_W-1:0] EV_BUTTON   = 2'd1;
    localparam logic [EV_W-1:0] EV_ROTATION = 2'd2;
    localparam logic [EV_W-1:0] EV_TIMEOUT  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_S_RD,
        ST_S_CMP,
        ST_C_RD,
        ST_C_LAT,
        ST_T_RD,
        ST_T_CMP,
        ST_N_RD,
        ST_N_LAT
    } t_ctl_state;

    typedef struct packed {
        logic accept;
        logic s_hit;
        logic s_next;
        logic c_rd;
        logic c_lat;
        logic t_hit;
        logic t_next;
        logic n_rd;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic step_go;
        logic s_end;
        logic s_eq;
        logic t_end;
        logic t_eq;
    } t_dp_sts;

endpackage

`default_nettype wire

/* design/table_driven_event_fsm_core.sv */
// Table-driven event state machine.
// Input channel: an operation is taken at a rising edge with i_start high
// and o_busy low. Loads of a state slot or a transition slot and setting the
// current state complete as they are taken and never raise o_busy. An event
// step with no pending event is taken and dropped likewise.
// An event step with an event raises o_busy and walks the state table, then
// the chosen slot's transitions through a single registered read port of each
// table memory; each entry is read in a read state and checked in a compare state.
// Result: o_valid pulses for one cycle right after o_busy falls; the result
// fields hold until the next result. The receiver cannot stall, and a new
// operation may be taken in the same cycle the result is shown.
// Configuration: states_in_use at APB byte address 0. The user must write it
// only while idle; the block does not enforce this.
// Reset clears the current state, states_in_use and o_valid; table memories
// are not cleared and are defined only once written.
`default_nettype none

module table_driven_event_fsm_core #(
    parameter int MAX_STATES = 16,
    parameter int MAX_TRANS  = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tdfsm_pkg::APB_AW-1:0] paddr,
    input  wire logic [tdfsm_pkg::APB_DW-1:0] pwdata,
    output logic [tdfsm_pkg::APB_DW-1:0]      prdata,
    output logic                              pready,
    input  wire logic                         i_start,
    output logic                              o_busy,
    input  wire logic [1:0]                   i_operation,
    input  wire logic [3:0]                   i_slot,
    input  wire logic [2:0]                   i_trans_slot,
    input  wire logic [7:0]                   i_state_code,
    input  wire logic [3:0]                   i_trans_count,
    input  wire logic [1:0]                   i_event_code,
    input  wire logic [7:0]                   i_next_state_code,
    input  wire logic                         i_button_event,
    input  wire logic signed [7:0]            i_rotation_amount,
    input  wire logic                         i_timer_event,
    output logic                              o_valid,
    output logic [1:0]                        o_chosen_event,
    output logic signed [7:0]                 o_event_rotation,
    output logic [3:0]                        o_found_state_slot,
    output logic [2:0]                        o_found_trans_slot,
    output logic [7:0]                        o_old_state,
    output logic [7:0]                        o_new_state,
    output logic                              o_state_matched,
    output logic                              o_trans_matched
);
    import tdfsm_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    tdfsm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    tdfsm_dp #(
        .MAX_STATES (MAX_STATES),
        .MAX_TRANS  (MAX_TRANS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_operation        (i_operation),
        .i_slot             (i_slot),
        .i_trans_slot       (i_trans_slot),
        .i_state_code       (i_state_code),
        .i_trans_count      (i_trans_count),
        .i_event_code       (i_event_code),
        .i_next_state_code  (i_next_state_code),
        .i_button_event     (i_button_event),
        .i_rotation_amount  (i_rotation_amount),
        .i_timer_event      (i_timer_event),
        .o_valid            (o_valid),
        .o_chosen_event     (o_chosen_event),
        .o_event_rotation   (o_event_rotation),
        .o_found_state_slot (o_found_state_slot),
        .o_found_trans_slot (o_found_trans_slot),
        .o_old_state        (o_old_state),
        .o_new_state        (o_new_state),
        .o_state_matched    (o_state_matched),
        .o_trans_matched    (o_trans_matched)
    );

endmodule

`default_nettype wire

/* design/tdfsm_ctrl.sv */
`default_nettype none

module tdfsm_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire tdfsm_pkg::t_dp_sts i_sts,
    output tdfsm_pkg::t_dp_cmd     o_cmd,
    output logic                   o_busy
);
    import tdfsm_pkg::*;

    t_ctl_state r_state;
    t_ctl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start && i_sts.step_go) n_state = ST_S_RD;
            end
            ST_S_RD: begin
                n_state = i_sts.s_end ? ST_C_RD : ST_S_CMP;
            end
            ST_S_CMP: begin
                n_state = i_sts.s_eq ? ST_C_RD : ST_S_RD;
            end
            ST_C_RD:  n_state = ST_C_LAT;
            ST_C_LAT: n_state = ST_T_RD;
            ST_T_RD: begin
                n_state = i_sts.t_end ? ST_N_RD : ST_T_CMP;
            end
            ST_T_CMP: begin
                n_state = i_sts.t_eq ? ST_N_RD : ST_T_RD;
            end
            ST_N_RD:  n_state = ST_N_LAT;
            ST_N_LAT: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_busy       = 1'b0;
                o_cmd.accept = i_start;
            end
            ST_S_CMP: begin
                o_cmd.s_hit  = i_sts.s_eq;
                o_cmd.s_next = !i_sts.s_eq;
            end
            ST_C_RD:  o_cmd.c_rd = 1'b1;
            ST_C_LAT: o_cmd.c_lat = 1'b1;
            ST_T_CMP: begin
                o_cmd.t_hit  = i_sts.t_eq;
                o_cmd.t_next = !i_sts.t_eq;
            end
            ST_N_RD:  o_cmd.n_rd = 1'b1;
            ST_N_LAT: o_cmd.finish = 1'b1;
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/tdfsm_dp.sv */
`default_nettype none

module tdfsm_dp #(
    parameter int MAX_STATES = 16,
    parameter int MAX_TRANS  = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire tdfsm_pkg::t_dp_cmd                i_cmd,
    output tdfsm_pkg::t_dp_sts                     o_sts,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [tdfsm_pkg::APB_AW-1:0]      paddr,
    input  wire logic [tdfsm_pkg::APB_DW-1:0]      pwdata,
    output logic [tdfsm_pkg::APB_DW-1:0]           prdata,
    output logic                                   pready,
    input  wire logic [1:0]                        i_operation,
    input  wire logic [3:0]                        i_slot,
    input  wire logic [2:0]                        i_trans_slot,
    input  wire logic [7:0]                        i_state_code,
    input  wire logic [3:0]                        i_trans_count,
    input  wire logic [1:0]                        i_event_code,
    input  wire logic [7:0]                        i_next_state_code,
    input  wire logic                              i_button_event,
    input  wire logic signed [7:0]                 i_rotation_amount,
    input  wire logic                              i_timer_event,
    output logic                                   o_valid,
    output logic [1:0]                             o_chosen_event,
    output logic signed [7:0]                      o_event_rotation,
    output logic [3:0]                             o_found_state_slot,
    output logic [2:0]                             o_found_trans_slot,
    output logic [7:0]                             o_old_state,
    output logic [7:0]                             o_new_state,
    output logic                                   o_state_matched,
    output logic                                   o_trans_matched
);
    import tdfsm_pkg::*;

    localparam int SW    = $clog2(MAX_STATES);
    localparam int TW    = (MAX_TRANS > 1) ? $clog2(MAX_TRANS) : 1;
    localparam int SCW   = SW + 1;
    localparam int TCW   = TW + 1;
    localparam int DEPTH = MAX_STATES * MAX_TRANS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SWW   = CODE_W + CNT_W;
    localparam int TWW   = EV_W + CODE_W;

    logic [SWW-1:0] state_mem [0:MAX_STATES-1];
    logic [TWW-1:0] trans_mem [0:DEPTH-1];

    logic [SIU_W-1:0]      r_siu;
    logic [CODE_W-1:0]     r_cur;
    logic [CODE_W-1:0]     r_old;
    logic [EV_W-1:0]       r_ev;
    logic signed [7:0]     r_rot;
    logic [SCW-1:0]        r_scnt;
    logic [SCW-1:0]        r_slim;
    logic [SW-1:0]         r_sidx;
    logic                  r_smatch;
    logic [TCW-1:0]        r_tcnt;
    logic [TCW-1:0]        r_tlim;
    logic [TW-1:0]         r_tidx;
    logic                  r_tmatch;
    logic [SWW-1:0]        r_sword;
    logic [TWW-1:0]        r_tword;

    logic                  cfg_wr;
    logic [8:0]            slot_w;
    logic [5:0]            ts_w;
    logic [SW-1:0]         slot_idx;
    logic [TW-1:0]         ts_idx;
    logic                  s_we;
    logic                  t_we;
    logic [AW-1:0]         t_waddr;
    logic [SW-1:0]         s_raddr;
    logic [AW-1:0]         t_raddr;
    logic [TW-1:0]         t_rsel;
    logic                  any_event;
    logic [EV_W-1:0]       ev_pick;
    logic [8:0]            siu_w;
    logic [8:0]            slim_w;
    logic [5:0]            cnt_w;
    logic [5:0]            tlim_w;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_STATES_IN_USE);
    assign prdata = (paddr[2] == REG_STATES_IN_USE) ? APB_DW'(r_siu) : '0;

    assign slot_w   = 9'(i_slot);
    assign ts_w     = 6'(i_trans_slot);
    assign slot_idx = slot_w[SW-1:0];
    assign ts_idx   = ts_w[TW-1:0];
    assign s_we     = i_cmd.accept && (t_op'(i_operation) == OP_LOAD_STATE)
                      && (slot_w < 9'(MAX_STATES));
    assign t_we     = i_cmd.accept && (t_op'(i_operation) == OP_LOAD_TRANS)
                      && (slot_w < 9'(MAX_STATES)) && (ts_w < 6'(MAX_TRANS));
    assign t_waddr  = AW'(slot_idx) * AW'(MAX_TRANS) + AW'(ts_idx);

    assign s_raddr  = i_cmd.c_rd ? r_sidx : r_scnt[SW-1:0];
    assign t_rsel   = i_cmd.n_rd ? r_tidx : r_tcnt[TW-1:0];
    assign t_raddr  = AW'(r_sidx) * AW'(MAX_TRANS) + AW'(t_rsel);

    assign any_event = i_button_event || (i_rotation_amount != 8'sd0) || i_timer_event;

    always_comb begin
        if (i_button_event) begin
            ev_pick = EV_BUTTON;
        end else if (i_rotation_amount != 8'sd0) begin
            ev_pick = EV_ROTATION;
        end else begin
            ev_pick = EV_TIMEOUT;
        end
    end

    assign siu_w  = 9'(r_siu);
    assign slim_w = (siu_w > 9'(MAX_STATES)) ? 9'(MAX_STATES) : siu_w;
    assign cnt_w  = 6'(r_sword[CNT_W-1:0]);
    assign tlim_w = (cnt_w > 6'(MAX_TRANS)) ? 6'(MAX_TRANS) : cnt_w;

    assign o_sts.step_go = (t_op'(i_operation) == OP_STEP) && any_event;
    assign o_sts.s_end   = (r_scnt == r_slim);
    assign o_sts.s_eq    = (r_sword[SWW-1:CNT_W] == r_old);
    assign o_sts.t_end   = (r_tcnt == r_tlim);
    assign o_sts.t_eq    = (r_tword[TWW-1:CODE_W] == r_ev);

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            state_mem[slot_idx] <= {i_state_code, i_trans_count};
        end
        r_sword <= state_mem[s_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (t_we) begin
            trans_mem[t_waddr] <= {i_event_code, i_next_state_code};
        end
        r_tword <= trans_mem[t_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_siu   <= '0;
            r_cur   <= '0;
            o_valid <= 1'b0;
        end else begin
            if (cfg_wr) r_siu <= pwdata[SIU_W-1:0];
            if (i_cmd.accept && (t_op'(i_operation) == OP_SET_STATE)) r_cur <= i_state_code;
            if (i_cmd.finish) r_cur <= r_tword[CODE_W-1:0];
            o_valid <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && o_sts.step_go) begin
            r_old    <= r_cur;
            r_ev     <= ev_pick;
            r_rot    <= (ev_pick == EV_ROTATION) ? i_rotation_amount : 8'sd0;
            r_scnt   <= '0;
            r_slim   <= SCW'(slim_w);
            r_sidx   <= '0;
            r_smatch <= 1'b0;
            r_tidx   <= '0;
            r_tmatch <= 1'b0;
        end
        if (i_cmd.s_next) r_scnt <= r_scnt + SCW'(1);
        if (i_cmd.s_hit) begin
            r_sidx   <= r_scnt[SW-1:0];
            r_smatch <= 1'b1;
        end
        if (i_cmd.c_lat) begin
            r_tcnt <= '0;
            r_tlim <= TCW'(tlim_w);
        end
        if (i_cmd.t_next) r_tcnt <= r_tcnt + TCW'(1);
        if (i_cmd.t_hit) begin
            r_tidx   <= r_tcnt[TW-1:0];
            r_tmatch <= 1'b1;
        end
        if (i_cmd.finish) begin
            o_chosen_event     <= r_ev;
            o_event_rotation   <= r_rot;
            o_found_state_slot <= 4'(r_sidx);
            o_found_trans_slot <= 3'(r_tidx);
            o_old_state        <= r_old;
            o_new_state        <= r_tword[CODE_W-1:0];
            o_state_matched    <= r_smatch;
            o_trans_matched    <= r_tmatch;
        end
    end

endmodule

`default_nettype wire

/* design/tdfsm_chk.sv */
`default_nettype none

module tdfsm_chk (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_start,
    input wire logic              o_busy,
    input wire logic [1:0]        i_operation,
    input wire logic              i_button_event,
    input wire logic signed [7:0] i_rotation_amount,
    input wire logic              i_timer_event,
    input wire logic              o_valid,
    input wire logic [1:0]        o_chosen_event,
    input wire logic signed [7:0] o_event_rotation,
    input wire logic [2:0]        o_found_trans_slot,
    input wire logic              o_trans_matched
);
    import tdfsm_pkg::*;

    logic step_xfer;

    assign step_xfer = i_start && !o_busy && (t_op'(i_operation) == OP_STEP)
                       && (i_button_event || (i_rotation_amount != 8'sd0) || i_timer_event);

    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_xfer |=> o_busy)
        else $error("event step transfer did not raise busy");

    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy && $past(o_busy))
        else $error("result strobe not at end of busy");

    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_rotation_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_chosen_event != EV_ROTATION)) |-> (o_event_rotation == 8'sd0))
        else $error("rotation reported with non-rotation event");

    a_trans_miss_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_trans_matched) |-> (o_found_trans_slot == 3'd0))
        else $error("transition miss without slot zero");

endmodule

bind table_driven_event_fsm_core tdfsm_chk u_tdfsm_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_start            (i_start),
    .o_busy             (o_busy),
    .i_operation        (i_operation),
    .i_button_event     (i_button_event),
    .i_rotation_amount  (i_rotation_amount),
    .i_timer_event      (i_timer_event),
    .o_valid            (o_valid),
    .o_chosen_event     (o_chosen_event),
    .o_event_rotation   (o_event_rotation),
    .o_found_trans_slot (o_found_trans_slot),
    .o_trans_matched    (o_trans_matched)
);

`default_nettype wire

/* dv/tdfsm_event_checker.sv */
`timescale 1ns / 100ps

module tdfsm_event_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic                           pready,
    input  wire logic [tdfsm_pkg::APB_AW-1:0]   paddr,
    input  wire logic [tdfsm_pkg::APB_DW-1:0]   pwdata,
    input  wire logic                           i_start,
    input  wire logic                           o_busy,
    input  wire logic [1:0]                     i_operation,
    input  wire logic [3:0]                     i_slot,
    input  wire logic [2:0]                     i_trans_slot,
    input  wire logic [7:0]                     i_state_code,
    input  wire logic [3:0]                     i_trans_count,
    input  wire logic [1:0]                     i_event_code,
    input  wire logic [7:0]                     i_next_state_code,
    input  wire logic                           i_button_event,
    input  wire logic signed [7:0]              i_rotation_amount,
    input  wire logic                           i_timer_event,
    input  wire logic                           o_valid,
    input  wire logic [1:0]                     o_chosen_event,
    input  wire logic signed [7:0]              o_event_rotation,
    input  wire logic [3:0]                     o_found_state_slot,
    input  wire logic [2:0]                     o_found_trans_slot,
    input  wire logic [7:0]                     o_old_state,
    input  wire logic [7:0]                     o_new_state,
    input  wire logic                           o_state_matched,
    input  wire logic                           o_trans_matched,
    output int                                  fail_count,
    output int                                  pending_results
);
    import tdfsm_pkg::*;

    localparam int N_STATES = 16;
    localparam int N_TRANS  = 8;
    localparam logic [APB_AW-1:0] SIU_ADDR = APB_AW'({REG_STATES_IN_USE, 2'b00});

    typedef struct packed {
        logic [1:0]        ev;
        logic signed [7:0] rot;
        logic [3:0]        s_slot;
        logic [2:0]        t_slot;
        logic [7:0]        old_st;
        logic [7:0]        new_st;
        logic              s_hit;
        logic              t_hit;
    } t_step_result;

    logic [7:0]         cur_state;
    logic [SIU_W-1:0]   states_in_use;
    logic [CODE_W-1:0]  st_code [N_STATES];
    logic [CNT_W-1:0]   st_cnt  [N_STATES];
    logic [EV_W-1:0]    tr_ev   [N_STATES][N_TRANS];
    logic [CODE_W-1:0]  tr_next [N_STATES][N_TRANS];
    t_step_result       step_results_q[$];
    t_step_result       expected_step;
    t_step_result       predicted_step;
    int                 mismatches = 0;

    function automatic t_step_result resolve_step(logic btn, logic signed [7:0] rot,
                                                  logic tmr);
        t_step_result r;
        int lim;
        r = '0;
        r.old_st = cur_state;
        if (btn) begin
            r.ev = EV_BUTTON;
        end else if (rot != 0) begin
            r.ev  = EV_ROTATION;
            r.rot = rot;
        end else begin
            r.ev = EV_TIMEOUT;
        end
        lim = (states_in_use > N_STATES) ? N_STATES : int'(states_in_use);
        for (int i = 0; i < lim && !r.s_hit; i++) begin
            if (st_code[i] == cur_state) begin
                r.s_slot = 4'(i);
                r.s_hit  = 1'b1;
            end
        end
        lim = (st_cnt[r.s_slot] > N_TRANS) ? N_TRANS : int'(st_cnt[r.s_slot]);
        for (int i = 0; i < lim && !r.t_hit; i++) begin
            if (tr_ev[r.s_slot][i] == r.ev) begin
                r.t_slot = 3'(i);
                r.t_hit  = 1'b1;
            end
        end
        r.new_st = tr_next[r.s_slot][r.t_slot];
        return r;
    endfunction

    task automatic check_field(input string name, input logic signed [31:0] exp_v,
                               input logic signed [31:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_state     = '0;
            states_in_use = '0;
            step_results_q.delete();
        end else begin
            if (o_valid) begin
                if (step_results_q.size() == 0) begin
                    $error("result transfer with no step outstanding");
                    mismatches++;
                end else begin
                    expected_step = step_results_q.pop_front();
                    check_field("chosen_event", expected_step.ev, o_chosen_event);
                    check_field("event_rotation", expected_step.rot, o_event_rotation);
                    check_field("found_state_slot", expected_step.s_slot,
                                o_found_state_slot);
                    check_field("found_trans_slot", expected_step.t_slot,
                                o_found_trans_slot);
                    check_field("old_state", expected_step.old_st, o_old_state);
                    check_field("new_state", expected_step.new_st, o_new_state);
                    check_field("state_matched", expected_step.s_hit, o_state_matched);
                    check_field("trans_matched", expected_step.t_hit, o_trans_matched);
                end
            end
            if (psel && penable && pwrite && pready && paddr == SIU_ADDR) begin
                states_in_use = pwdata[SIU_W-1:0];
            end
            if (i_start && !o_busy) begin
                case (t_op'(i_operation))
                    OP_LOAD_STATE: begin
                        st_code[i_slot] = i_state_code;
                        st_cnt[i_slot]  = i_trans_count;
                    end
                    OP_LOAD_TRANS: begin
                        tr_ev[i_slot][i_trans_slot]   = i_event_code;
                        tr_next[i_slot][i_trans_slot] = i_next_state_code;
                    end
                    OP_SET_STATE: begin
                        cur_state = i_state_code;
                    end
                    OP_STEP: begin
                        if (i_button_event || i_rotation_amount != 0 || i_timer_event) begin
                            predicted_step = resolve_step(i_button_event,
                                                          i_rotation_amount,
                                                          i_timer_event);
                            cur_state = predicted_step.new_st;
                            step_results_q.push_back(predicted_step);
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        pending_results <= step_results_q.size();
        fail_count      <= mismatches;
    end

endmodule

/* dv/tb_table_driven_event_fsm_core.sv */
`timescale 1ns / 100ps

module tb_table_driven_event_fsm_core;
    import tdfsm_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int ITEM_TARGET  = 1650;
    localparam int PHASE_ITEMS  = 135;
    localparam int DRAIN_CYCLES = 60;
    localparam int N_STATES     = 16;
    localparam int N_TRANS      = 8;
    localparam logic [EV_W-1:0] EV_NONE = 2'd0;
    localparam logic [APB_AW-1:0] SIU_ADDR = APB_AW'({REG_STATES_IN_USE, 2'b00});

    typedef struct {
        t_op               op;
        logic [3:0]        slot;
        logic [2:0]        tslot;
        logic [7:0]        code;
        logic [3:0]        cnt;
        logic [1:0]        ev;
        logic [7:0]        next;
        logic              btn;
        logic signed [7:0] rot;
        logic              tmr;
    } t_fsm_cmd;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;
    logic                  i_start;
    logic                  o_busy;
    logic [1:0]            i_operation;
    logic [3:0]            i_slot;
    logic [2:0]            i_trans_slot;
    logic [7:0]            i_state_code;
    logic [3:0]            i_trans_count;
    logic [1:0]            i_event_code;
    logic [7:0]            i_next_state_code;
    logic                  i_button_event;
    logic signed [7:0]     i_rotation_amount;
    logic                  i_timer_event;
    logic                  o_valid;
    logic [1:0]            o_chosen_event;
    logic signed [7:0]     o_event_rotation;
    logic [3:0]            o_found_state_slot;
    logic [2:0]            o_found_trans_slot;
    logic [7:0]            o_old_state;
    logic [7:0]            o_new_state;
    logic                  o_state_matched;
    logic                  o_trans_matched;

    int                    fail_count;
    int                    pending_results;
    int                    items_sent = 0;
    int                    idle_pct   = 11;
    int                    cycle_cnt  = 0;
    logic [SIU_W-1:0]      siu_shadow = '0;
    bit                    st_written [N_STATES];
    logic [3:0]            st_cnt_shadow [N_STATES];
    bit                    tr_written [N_STATES][N_TRANS];

    table_driven_event_fsm_core u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_start            (i_start),
        .o_busy             (o_busy),
        .i_operation        (i_operation),
        .i_slot             (i_slot),
        .i_trans_slot       (i_trans_slot),
        .i_state_code       (i_state_code),
        .i_trans_count      (i_trans_count),
        .i_event_code       (i_event_code),
        .i_next_state_code  (i_next_state_code),
        .i_button_event     (i_button_event),
        .i_rotation_amount  (i_rotation_amount),
        .i_timer_event      (i_timer_event),
        .o_valid            (o_valid),
        .o_chosen_event     (o_chosen_event),
        .o_event_rotation   (o_event_rotation),
        .o_found_state_slot (o_found_state_slot),
        .o_found_trans_slot (o_found_trans_slot),
        .o_old_state        (o_old_state),
        .o_new_state        (o_new_state),
        .o_state_matched    (o_state_matched),
        .o_trans_matched    (o_trans_matched)
    );

    tdfsm_event_checker u_chk (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .pready             (pready),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .i_start            (i_start),
        .o_busy             (o_busy),
        .i_operation        (i_operation),
        .i_slot             (i_slot),
        .i_trans_slot       (i_trans_slot),
        .i_state_code       (i_state_code),
        .i_trans_count      (i_trans_count),
        .i_event_code       (i_event_code),
        .i_next_state_code  (i_next_state_code),
        .i_button_event     (i_button_event),
        .i_rotation_amount  (i_rotation_amount),
        .i_timer_event      (i_timer_event),
        .o_valid            (o_valid),
        .o_chosen_event     (o_chosen_event),
        .o_event_rotation   (o_event_rotation),
        .o_found_state_slot (o_found_state_slot),
        .o_found_trans_slot (o_found_trans_slot),
        .o_old_state        (o_old_state),
        .o_new_state        (o_new_state),
        .o_state_matched    (o_state_matched),
        .o_trans_matched    (o_trans_matched),
        .fail_count         (fail_count),
        .pending_results    (pending_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("FAIL table_driven_event_fsm_core");
        $finish;
    end

    function automatic logic [7:0] rand_code();
        case ($urandom_range(0, 9))
            0:       return 8'($urandom());
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 7));
        endcase
    endfunction

    function automatic logic [1:0] rand_trans_event();
        if ($urandom_range(0, 9) == 0) return EV_NONE;
        return 2'($urandom_range(1, 3));
    endfunction

    function automatic int searched_slots();
        int n;
        n = (siu_shadow > N_STATES) ? N_STATES : int'(siu_shadow);
        return (n == 0) ? 1 : n;
    endfunction

    function automatic bit slot_ready(int s);
        int k;
        k = (st_cnt_shadow[s] > N_TRANS) ? N_TRANS : int'(st_cnt_shadow[s]);
        if (k == 0) k = 1;
        if (!st_written[s]) return 1'b0;
        for (int t = 0; t < k; t++) begin
            if (!tr_written[s][t]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_fsm_cmd noise_cmd();
        t_fsm_cmd c;
        c.op    = t_op'($urandom_range(0, 3));
        c.slot  = 4'($urandom());
        c.tslot = 3'($urandom());
        c.code  = 8'($urandom());
        c.cnt   = 4'($urandom());
        c.ev    = 2'($urandom());
        c.next  = 8'($urandom());
        c.btn   = 1'($urandom());
        c.rot   = 8'($urandom());
        c.tmr   = 1'($urandom());
        return c;
    endfunction

    task automatic send(input t_fsm_cmd c);
        bit taken = 1'b0;
        while (!taken) begin
            if ($urandom_range(0, 99) < idle_pct) begin
                i_start <= 1'b0;
                @(posedge i_clk);
            end else begin
                i_start           <= 1'b1;
                i_operation       <= c.op;
                i_slot            <= c.slot;
                i_trans_slot      <= c.tslot;
                i_state_code      <= c.code;
                i_trans_count     <= c.cnt;
                i_event_code      <= c.ev;
                i_next_state_code <= c.next;
                i_button_event    <= c.btn;
                i_rotation_amount <= c.rot;
                i_timer_event     <= c.tmr;
                @(posedge i_clk);
                taken = !o_busy;
            end
        end
        if (c.op == OP_LOAD_STATE) begin
            st_written[c.slot]    = 1'b1;
            st_cnt_shadow[c.slot] = c.cnt;
        end
        if (c.op == OP_LOAD_TRANS) tr_written[c.slot][c.tslot] = 1'b1;
        if (!(c.op == OP_STEP && !c.btn && c.rot == 0 && !c.tmr)) items_sent++;
    endtask

    task automatic load_state(input logic [3:0] s, input logic [7:0] code,
                              input logic [3:0] cnt);
        t_fsm_cmd c;
        c      = noise_cmd();
        c.op   = OP_LOAD_STATE;
        c.slot = s;
        c.code = code;
        c.cnt  = cnt;
        send(c);
    endtask

    task automatic load_trans(input logic [3:0] s, input logic [2:0] t,
                              input logic [1:0] ev, input logic [7:0] next);
        t_fsm_cmd c;
        c       = noise_cmd();
        c.op    = OP_LOAD_TRANS;
        c.slot  = s;
        c.tslot = t;
        c.ev    = ev;
        c.next  = next;
        send(c);
    endtask

    task automatic set_state(input logic [7:0] code);
        t_fsm_cmd c;
        c      = noise_cmd();
        c.op   = OP_SET_STATE;
        c.code = code;
        send(c);
    endtask

    task automatic step(input logic btn, input logic signed [7:0] rot, input logic tmr);
        t_fsm_cmd c;
        c     = noise_cmd();
        c.op  = OP_STEP;
        c.btn = btn;
        c.rot = rot;
        c.tmr = tmr;
        send(c);
    endtask

    task automatic program_slot(input logic [3:0] s, input logic [3:0] cnt);
        int k;
        k = (cnt > N_TRANS) ? N_TRANS : int'(cnt);
        if (k == 0) k = 1;
        load_state(s, rand_code(), cnt);
        for (int t = 0; t < k; t++) load_trans(s, 3'(t), rand_trans_event(), rand_code());
    endtask

    // fill every entry the next lookup may touch
    task automatic ensure_tables();
        for (int s = 0; s < searched_slots(); s++) begin
            if (!slot_ready(s)) program_slot(4'(s), 4'($urandom_range(0, 8)));
        end
    endtask

    task automatic random_step();
        logic btn;
        logic signed [7:0] rot;
        logic tmr;
        int r;
        r   = $urandom_range(0, 19);
        btn = ($urandom_range(0, 2) == 0);
        rot = $urandom_range(0, 1) ? 8'($urandom_range(1, 255)) : 8'sd0;
        tmr = 1'($urandom());
        if (r == 0) begin
            btn = 1'b0;
            rot = 8'sd0;
            tmr = 1'b0;
        end else if (r == 1) begin
            rot = -8'sd128;
        end else if (r == 2) begin
            rot = 8'sd127;
        end
        ensure_tables();
        step(btn, rot, tmr);
    endtask

    task automatic random_item();
        int r;
        logic [3:0] s;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            s = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, searched_slots() - 1))
                                           : 4'($urandom());
            program_slot(s, ($urandom_range(0, 6) == 0) ? 4'($urandom_range(9, 15))
                                                        : 4'($urandom_range(0, 8)));
        end else if (r < 17) begin
            load_trans(4'($urandom()), 3'($urandom()), 2'($urandom()), rand_code());
        end else if (r < 20) begin
            load_state(4'($urandom()), rand_code(), 4'($urandom()));
        end else if (r < 30) begin
            set_state(rand_code());
        end else begin
            random_step();
        end
    endtask

    task automatic quiesce();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0 || o_busy) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_states_in_use(input logic [SIU_W-1:0] v);
        quiesce();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SIU_ADDR;
        pwdata  <= ($urandom() & ~32'h1F) | 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        siu_shadow = v;
    endtask

    initial begin
        int phase;
        logic [SIU_W-1:0] siu_pick;
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        i_start           = 1'b0;
        i_operation       = '0;
        i_slot            = '0;
        i_trans_slot      = '0;
        i_state_code      = '0;
        i_trans_count     = '0;
        i_event_code      = '0;
        i_next_state_code = '0;
        i_button_event    = 1'b0;
        i_rotation_amount = '0;
        i_timer_event     = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        load_state(4'd0, 8'h00, 4'd2);
        load_trans(4'd0, 3'd0, EV_BUTTON, 8'hFF);
        load_trans(4'd0, 3'd1, EV_NONE, 8'h11);
        step(1'b0, 8'sd0, 1'b0);
        step(1'b1, 8'sd0, 1'b0);
        step(1'b0, 8'sd127, 1'b0);
        write_states_in_use(5'd2);
        load_state(4'd1, 8'hFF, 4'd15);
        load_trans(4'd1, 3'd0, EV_NONE, 8'h5A);
        load_trans(4'd1, 3'd1, EV_TIMEOUT, 8'h00);
        for (int t = 2; t < 6; t++) load_trans(4'd1, 3'(t), EV_NONE, 8'(8'h30 + t));
        load_trans(4'd1, 3'd6, EV_ROTATION, 8'h00);
        load_trans(4'd1, 3'd7, EV_BUTTON, 8'h00);
        step(1'b1, -8'sd128, 1'b1);
        step(1'b0, 8'sd0, 1'b1);
        step(1'b0, -8'sd128, 1'b1);
        set_state(8'h80);
        step(1'b0, 8'sd0, 1'b1);
        load_state(4'd0, 8'h00, 4'd0);
        set_state(8'h00);
        step(1'b1, 8'sd0, 1'b0);

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            case (phase)
                0:       siu_pick = 5'd16;
                1:       siu_pick = 5'd0;
                2:       siu_pick = 5'd31;
                3:       siu_pick = 5'd1;
                4:       siu_pick = 5'd16;
                5:       siu_pick = 5'd17;
                default: siu_pick = 5'($urandom_range(0, 31));
            endcase
            write_states_in_use(siu_pick);
            // hold start steady through two whole phases
            idle_pct = (phase == 4 || phase == 5) ? 0 : 11;
            for (int n = 0; n < PHASE_ITEMS && items_sent < ITEM_TARGET; n++) random_item();
            phase++;
        end

        quiesce();
        if (fail_count == 0) begin
            $display("PASS table_driven_event_fsm_core");
        end else begin
            $display("FAIL table_driven_event_fsm_core");
        end
        $finish;
    end

endmodule
